// File: hw/rtl/motor_feedback_turn_tracker_top_defines.svh
// Assertion macros for the motor feedback turn tracker.
// Included by the top level; expects i_clk and i_rst_n in scope.
`ifndef MOTOR_FEEDBACK_TURN_TRACKER_TOP_DEFINES_SVH
`define MOTOR_FEEDBACK_TURN_TRACKER_TOP_DEFINES_SVH

// Condition in the same cycle implies consequence in the same cycle.
`define MFTT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Condition implies consequence in the next cycle.
`define MFTT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/mftt_pkg.sv
// Shared constants and types of the motor feedback turn tracker.
// No dependencies; used by every module of the block.
package mftt_pkg;

    localparam int SLOT_COUNT      = 32;
    localparam int TABLE_ENTRIES   = 8;
    localparam int REG_COUNT       = 8;
    localparam int COUNTS_PER_TURN = 8192;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    // Command kinds passed from front to back
    localparam logic [1:0] CMD_NONE     = 2'd0;
    localparam logic [1:0] CMD_FEEDBACK = 2'd1;
    localparam logic [1:0] CMD_TARGET   = 2'd2;

    // Encoder types
    localparam logic [1:0] TYPE_ABSOLUTE = 2'd1;

    // Item functions
    localparam logic FUNC_FEEDBACK = 1'b0;
    localparam logic FUNC_TARGET   = 1'b1;

    typedef struct packed {
        logic [1:0]         kind;
        logic [4:0]         slot;
        logic [1:0]         enc_type;   // entry type, or fallback type for targets
        logic [12:0]        angle;      // clamped encoder or target angle
        logic signed [15:0] speed;
        logic signed [15:0] current;
        logic [7:0]         temp;
        logic signed [15:0] tgt_turns;
    } t_cmd;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_q_stat;

    typedef struct packed {
        logic               matched;
        logic [4:0]         slot;
        logic [12:0]        angle;
        logic signed [15:0] speed;
        logic signed [15:0] current;
        logic [7:0]         temperature;
        logic signed [31:0] turn_count;
        logic signed [13:0] tgt_offset;
    } t_result;

endpackage

// File: hw/rtl/mftt_front.sv
// Front end: match table registers, input item decode and classification.
// Depends on mftt_pkg; pushes one command per accepted item into the queue.
module mftt_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [20:0]          i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_func,
    input  logic [103:0]         i_in_data,
    input  mftt_pkg::t_q_stat    i_q_stat,
    output logic                 o_in_ready,
    output logic                 o_push,
    output mftt_pkg::t_cmd       o_cmd
);

    logic [20:0] r_entry [mftt_pkg::REG_COUNT];

    logic [1:0]         in_port;
    logic [10:0]        in_id;
    logic [15:0]        in_enc;
    logic [4:0]         in_tslot;
    logic [12:0]        in_tangle;
    logic               hit;
    logic [4:0]         hit_slot;
    logic [1:0]         hit_type;
    logic [1:0]         fb_type;
    logic [12:0]        enc_clamped;

    assign in_port   = i_in_data[1:0];
    assign in_id     = i_in_data[12:2];
    assign in_enc    = i_in_data[28:13];
    assign in_tslot  = i_in_data[73:69];
    assign in_tangle = i_in_data[86:74];

    // Table registers, written from the configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mftt_pkg::REG_COUNT; i++) begin
                r_entry[i] <= '0;
            end
        end else if (i_cfg_we) begin
            r_entry[i_cfg_index] <= i_cfg_data;
        end
    end

    // Priority match: scan downward so the lowest index wins
    always_comb begin
        hit      = 1'b0;
        hit_slot = '0;
        hit_type = '0;
        for (int i = mftt_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (r_entry[i][20] && (r_entry[i][19:18] != 2'd0) &&
                (r_entry[i][19:18] == in_port) && (r_entry[i][17:7] == in_id)) begin
                hit      = 1'b1;
                hit_slot = r_entry[i][4:0];
                hit_type = r_entry[i][6:5];
            end
        end
    end

    // Fallback type of a target slot: last valid entry naming that slot
    always_comb begin
        fb_type = '0;
        for (int i = 0; i < mftt_pkg::TABLE_ENTRIES; i++) begin
            if (r_entry[i][20] && (r_entry[i][4:0] == in_tslot)) begin
                fb_type = r_entry[i][6:5];
            end
        end
    end

    // Saturate encoder reading to one turn
    assign enc_clamped = (in_enc > 16'(mftt_pkg::COUNTS_PER_TURN - 1))
                       ? 13'(mftt_pkg::COUNTS_PER_TURN - 1) : in_enc[12:0];

    // Build the command
    always_comb begin
        o_cmd           = '0;
        o_cmd.speed     = $signed(i_in_data[44:29]);
        o_cmd.current   = $signed(i_in_data[60:45]);
        o_cmd.temp      = i_in_data[68:61];
        o_cmd.tgt_turns = $signed(i_in_data[102:87]);
        if (i_func == mftt_pkg::FUNC_TARGET) begin
            o_cmd.slot     = in_tslot;
            o_cmd.enc_type = fb_type;
            o_cmd.angle    = (in_tangle > 13'(mftt_pkg::COUNTS_PER_TURN - 1))
                           ? 13'(mftt_pkg::COUNTS_PER_TURN - 1) : in_tangle;
            o_cmd.kind     = ({1'b0, in_tslot} < 6'(mftt_pkg::SLOT_COUNT))
                           ? mftt_pkg::CMD_TARGET : mftt_pkg::CMD_NONE;
        end else begin
            o_cmd.slot     = hit_slot;
            o_cmd.enc_type = hit_type;
            o_cmd.angle    = enc_clamped;
            o_cmd.kind     = (hit && ({1'b0, hit_slot} < 6'(mftt_pkg::SLOT_COUNT)))
                           ? mftt_pkg::CMD_FEEDBACK : mftt_pkg::CMD_NONE;
        end
    end

    assign o_in_ready = !i_q_stat.full;
    assign o_push     = i_in_valid && !i_q_stat.full;

endmodule

// File: hw/rtl/mftt_queue.sv
// Short command queue between the front and the back end.
// Depends on mftt_pkg for the command type and depth.
module mftt_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mftt_pkg::t_cmd     i_cmd,
    input  logic               i_pop,
    output mftt_pkg::t_cmd     o_cmd,
    output mftt_pkg::t_q_stat  o_stat
);

    mftt_pkg::t_cmd                 r_q [mftt_pkg::QUEUE_DEPTH];
    logic [mftt_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [mftt_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [mftt_pkg::QCNT_W-1:0]    r_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_stat.full  = (r_count == mftt_pkg::QCNT_W'(mftt_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.count = r_count;
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_cmd        = r_q[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == mftt_pkg::QPTR_W'(mftt_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == mftt_pkg::QPTR_W'(mftt_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/mftt_back.sv
// Back end: per-slot state memory, read-modify-write sequencer, result register.
// Depends on mftt_pkg; takes commands from mftt_queue.
module mftt_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mftt_pkg::t_cmd     i_cmd,
    input  logic               i_q_empty,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mftt_pkg::t_result  o_result
);

    typedef struct packed {
        logic [12:0]        angle;
        logic signed [31:0] turns;
        logic [12:0]        target;
        logic signed [15:0] tgt_turns;
        logic signed [13:0] diff;
    } t_slot_rec;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CALC  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    localparam logic signed [17:0] TURN_LIM = 18'sd5 * 18'(mftt_pkg::COUNTS_PER_TURN);
    localparam logic signed [14:0] HALF     = 15'(mftt_pkg::COUNTS_PER_TURN / 2);
    localparam logic signed [14:0] FULL     = 15'(mftt_pkg::COUNTS_PER_TURN);

    t_slot_rec r_mem [mftt_pkg::SLOT_COUNT];
    t_slot_rec r_rdata;
    logic      r_rd_vld;

    logic [mftt_pkg::SLOT_COUNT-1:0] r_slot_vld;
    logic [mftt_pkg::SLOT_COUNT-1:0] r_type_known;
    logic [1:0]                      r_type [mftt_pkg::SLOT_COUNT];

    logic [1:0]         r_state, n_state;
    mftt_pkg::t_cmd     r_cmd;
    t_slot_rec          r_new, n_new;
    mftt_pkg::t_result  r_res, n_res;
    logic               r_do_write, n_do_write;
    logic               r_out_valid;
    mftt_pkg::t_result  r_out;

    t_slot_rec          old_rec;
    logic [1:0]         eff_type;
    logic signed [13:0] delta;
    logic signed [17:0] delta6;
    logic signed [13:0] fb_diff;
    logic signed [13:0] tg_diff;
    logic               out_free;
    logic               load_out;

    // Shortest signed difference target - angle within half a turn
    function automatic logic signed [13:0] short_diff(input logic [12:0] tgt,
                                                      input logic [12:0] ang);
        logic signed [14:0] d;
        begin
            d = $signed({2'b00, tgt}) - $signed({2'b00, ang});
            if (d > HALF) begin
                d = d - FULL;
            end else if (d < -HALF) begin
                d = d + FULL;
            end
            return d[13:0];
        end
    endfunction

    assign out_free = !r_out_valid || i_out_ready;
    assign load_out = (r_state == ST_WRITE) && out_free;
    assign o_pop    = (r_state == ST_IDLE) && !i_q_empty;

    // Slot memory: registered read, single write port
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rdata <= r_mem[i_cmd.slot];
        end
        if (load_out && r_do_write) begin
            r_mem[r_cmd.slot] <= r_new;
        end
    end

    // Sequencer state and latched command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (o_pop) begin
            r_cmd    <= i_cmd;
            r_rd_vld <= r_slot_vld[i_cmd.slot];
        end
        if (r_state == ST_CALC) begin
            r_new      <= n_new;
            r_res      <= n_res;
            r_do_write <= n_do_write;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (!i_q_empty) n_state = ST_CALC;
            ST_CALC:  n_state = ST_WRITE;
            ST_WRITE: if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Per-slot valid bits and last seen encoder type
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_vld   <= '0;
            r_type_known <= '0;
        end else if (load_out && r_do_write) begin
            r_slot_vld[r_cmd.slot] <= 1'b1;
            if (r_cmd.kind == mftt_pkg::CMD_FEEDBACK) begin
                r_type_known[r_cmd.slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out && r_do_write && (r_cmd.kind == mftt_pkg::CMD_FEEDBACK)) begin
            r_type[r_cmd.slot] <= r_cmd.enc_type;
        end
    end

    // Update arithmetic on the read record
    assign old_rec  = r_rd_vld ? r_rdata : '0;
    assign eff_type = r_type_known[r_cmd.slot] ? r_type[r_cmd.slot] : r_cmd.enc_type;
    assign delta    = $signed({1'b0, r_cmd.angle}) - $signed({1'b0, old_rec.angle});
    assign delta6   = 18'(delta) * 18'sd6;
    assign fb_diff  = short_diff(old_rec.target, r_cmd.angle);
    assign tg_diff  = short_diff(r_cmd.angle, old_rec.angle);

    always_comb begin
        n_new      = old_rec;
        n_res      = '0;
        n_do_write = 1'b0;
        case (r_cmd.kind)
            mftt_pkg::CMD_FEEDBACK: begin
                n_do_write        = 1'b1;
                n_new.angle       = r_cmd.angle;
                n_res.matched     = 1'b1;
                n_res.slot        = r_cmd.slot;
                n_res.angle       = r_cmd.angle;
                n_res.speed       = r_cmd.speed;
                n_res.current     = r_cmd.current;
                n_res.temperature = r_cmd.temp;
                if (r_cmd.enc_type == mftt_pkg::TYPE_ABSOLUTE) begin
                    n_new.diff       = fb_diff;
                    n_new.turns      = '0;
                    n_res.tgt_offset = fb_diff;
                end else if (delta6 < -TURN_LIM) begin
                    n_new.turns = old_rec.turns + 32'sd1;
                end else if (delta6 > TURN_LIM) begin
                    n_new.turns = old_rec.turns - 32'sd1;
                end
                n_res.turn_count = n_new.turns;
            end
            mftt_pkg::CMD_TARGET: begin
                n_do_write       = 1'b1;
                n_new.target     = r_cmd.angle;
                n_new.tgt_turns  = r_cmd.tgt_turns;
                n_res.matched    = 1'b1;
                n_res.slot       = r_cmd.slot;
                n_res.angle      = old_rec.angle;
                n_res.turn_count = old_rec.turns;
                if (eff_type == mftt_pkg::TYPE_ABSOLUTE) begin
                    n_new.diff       = tg_diff;
                    n_res.tgt_offset = tg_diff;
                end
            end
            default: begin
                n_do_write = 1'b0;
            end
        endcase
    end

    // Result register toward the output channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (load_out) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

// File: hw/rtl/motor_feedback_turn_tracker_top.sv
// Motor feedback turn tracker, top level.
// Depends on mftt_pkg, mftt_front, mftt_queue, mftt_back and the defines header.
//
// Usage:
//   Input stream (s_axis): one item per feedback frame or set-target request;
//   tuser carries func (0 feedback, 1 set target). Output stream (m_axis):
//   exactly one result item per input item, in order; tuser is the matched flag.
//   Configuration: i_cfg_we writes i_cfg_data into table entry i_cfg_index
//   (0 = highest priority) at the clock edge; write only while idle.
//   An accepted item goes through the command queue, memory read, update and
//   result register. The back end takes a new item only after it has finished
//   the read-modify-write of the slot memory (read, compute, write) for the last one; a stalled output holds it.
//   A two-entry command queue lets the input accept up to two items while the
//   back end works or the output is stalled; with the receiver stalled the
//   result register holds and input ready drops once the queue is full.
//   Reset (synchronous, active low) clears the table, the queue, the result
//   register and the per-slot valid and type-known bits; slot state then reads
//   as zero without any clearing pass.
`include "motor_feedback_turn_tracker_top_defines.svh"

module motor_feedback_turn_tracker_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_index,
    input  logic [20:0]   i_cfg_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // bus_port, frame_id, encoder_raw, speed_raw, current_raw, temp_raw,
    // target_slot, goal_angle, target_turns, one zero pad bit
    input  logic [103:0]  s_axis_tdata,
    input  logic          s_axis_tuser,   // func
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // slot, angle, speed, current, temperature, turn_count, tgt_offset
    output logic [103:0]  m_axis_tdata,
    output logic          m_axis_tuser    // matched
);

    mftt_pkg::t_cmd     front_cmd;
    mftt_pkg::t_cmd     q_cmd;
    mftt_pkg::t_q_stat  q_stat;
    mftt_pkg::t_result  result;
    logic               push;
    logic               pop;

    mftt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (s_axis_tvalid),
        .i_func      (s_axis_tuser),
        .i_in_data   (s_axis_tdata),
        .i_q_stat    (q_stat),
        .o_in_ready  (s_axis_tready),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    mftt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (q_cmd),
        .o_stat  (q_stat)
    );

    mftt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_q_empty   (q_stat.empty),
        .o_pop       (pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_result    (result)
    );

    // Output packing, first field in the lowest bits
    assign m_axis_tuser = result.matched;
    assign m_axis_tdata = {result.tgt_offset, result.turn_count, result.temperature,
                           result.current, result.speed, result.angle, result.slot};

    // Checks
    `MFTT_ASSERT_SAME(a_unmatched_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0, "unmatched result carries nonzero fields")
    `MFTT_ASSERT_SAME(a_queue_bound, 1'b1, q_stat.count <= mftt_pkg::QCNT_W'(mftt_pkg::QUEUE_DEPTH), "command queue over depth")
    `MFTT_ASSERT_NEXT(a_accept_queued, s_axis_tvalid && s_axis_tready, !q_stat.empty, "accepted item not in queue")
    `MFTT_ASSERT_SAME(a_ready_full, !s_axis_tready, q_stat.full, "input stalled with queue space")

endmodule

// File: tb/motor_feedback_turn_tracker_top_test.sv
// Self-checking testbench for the motor feedback turn tracker top level.
// Needs mftt_pkg and the RTL of motor_feedback_turn_tracker_top; reads no files.
`timescale 1ns / 100ps

module motor_feedback_turn_tracker_top_test;

    // Local names for the package constants and types used below
    localparam int         SLOT_COUNT      = mftt_pkg::SLOT_COUNT;
    localparam int         TABLE_ENTRIES   = mftt_pkg::TABLE_ENTRIES;
    localparam int         REG_COUNT       = mftt_pkg::REG_COUNT;
    localparam int         COUNTS_PER_TURN = mftt_pkg::COUNTS_PER_TURN;
    localparam logic       FUNC_FEEDBACK   = mftt_pkg::FUNC_FEEDBACK;
    localparam logic       FUNC_TARGET     = mftt_pkg::FUNC_TARGET;
    localparam logic [1:0] TYPE_ABSOLUTE   = mftt_pkg::TYPE_ABSOLUTE;
    typedef mftt_pkg::t_result t_result;

    // Incremental encoder types
    localparam logic [1:0] TYPE_INCR_A = 2'd0;
    localparam logic [1:0] TYPE_INCR_B = 2'd2;
    localparam logic [1:0] TYPE_INCR_C = 2'd3;

    localparam int STALL_LIMIT = 2000;
    localparam int HALF_TURN   = COUNTS_PER_TURN / 2;
    localparam int PLAN_ROWS   = 24;

    // Input item payload, lowest field in the lowest bits
    typedef struct packed {
        logic               pad;
        logic signed [15:0] target_turns;
        logic [12:0]        goal_angle;
        logic [4:0]         target_slot;
        logic [7:0]         temp_raw;
        logic signed [15:0] current_raw;
        logic signed [15:0] speed_raw;
        logic [15:0]        encoder_raw;
        logic [10:0]        frame_id;
        logic [1:0]         bus_port;
    } t_frame;

    typedef struct {
        bit      on;
        t_result r;
    } t_typed_result;

    typedef struct {
        logic        func;
        logic [1:0]  port;
        logic [10:0] id;
        logic [15:0] enc;
        logic [15:0] spd;
        logic [15:0] cur;
        logic [7:0]  temp;
        logic [4:0]  tslot;
        logic [12:0] tangle;
        logic [15:0] tturns;
        bit          on;
        t_result     gold;
    } t_plan_row;

    logic          i_clk         = 1'b0;
    logic          i_rst_n       = 1'b0;
    logic          i_cfg_we      = 1'b0;
    logic [2:0]    i_cfg_index   = '0;
    logic [20:0]   i_cfg_data    = '0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [103:0]  s_axis_tdata  = '0;  // bus_port .. target_turns, pad
    logic          s_axis_tuser  = 1'b0; // func
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [103:0]  m_axis_tdata;        // slot, angle, speed, current, temp, turns, offset
    logic          m_axis_tuser;        // matched

    motor_feedback_turn_tracker_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the match table and of the per-slot tracking state
    logic [20:0]        table_regs      [REG_COUNT]  = '{default: '0};
    logic [12:0]        angle_mem       [SLOT_COUNT] = '{default: '0};
    logic [31:0]        turns_mem       [SLOT_COUNT] = '{default: '0};
    logic [12:0]        target_mem      [SLOT_COUNT] = '{default: '0};
    logic [15:0]        target_turn_mem [SLOT_COUNT] = '{default: '0};
    logic signed [13:0] diff_mem        [SLOT_COUNT] = '{default: '0};
    logic [1:0]         type_mem        [SLOT_COUNT] = '{default: '0};
    bit                 type_seen       [SLOT_COUNT] = '{default: 1'b0};

    t_result       pending_results [$];
    t_typed_result hand_results    [$];
    int  items_sent    = 0;
    int  results_seen  = 0;
    int  matched_seen  = 0;
    int  fail_count    = 0;
    int  quiet_cycles  = 0;
    int  stall_left    = 0;
    bit  idle_on       = 1'b0;

    // Directed table: priority, port zero, invalid entry, every encoder type
    logic [20:0] dir_table [REG_COUNT] = '{
        {1'b1, 2'd1, 11'h201, TYPE_INCR_A,   5'd3},
        {1'b1, 2'd2, 11'h201, TYPE_ABSOLUTE, 5'd7},
        {1'b1, 2'd1, 11'h201, TYPE_ABSOLUTE, 5'd9},   // shadowed by entry zero
        {1'b1, 2'd0, 11'h7FF, TYPE_ABSOLUTE, 5'd4},   // port zero never matches
        {1'b0, 2'd3, 11'h123, TYPE_ABSOLUTE, 5'd5},   // not valid
        {1'b1, 2'd3, 11'h7FF, TYPE_INCR_C,   5'd31},
        {1'b1, 2'd3, 11'h000, TYPE_INCR_B,   5'd0},
        {1'b1, 2'd2, 11'h0AA, TYPE_ABSOLUTE, 5'd12}
    };

    // Directed items; gold typed in where it is obvious, else predicted
    t_plan_row plan [PLAN_ROWS] = '{
        '{FUNC_FEEDBACK, 2'd1, 11'h201, 16'd0, 16'h7FFF, 16'h8000, 8'hFF, 5'd0, 13'd0, 16'd0,
          1'b1, {1'b1, 5'd3, 13'd0, 16'h7FFF, 16'h8000, 8'hFF, 32'd0, 14'd0}},
        // saturates to full scale, wraps down one turn
        '{FUNC_FEEDBACK, 2'd1, 11'h201, 16'hFFFF, 16'h8000, 16'h7FFF, 8'h00, 5'd0, 13'd0, 16'd0,
          1'b1, {1'b1, 5'd3, 13'd8191, 16'h8000, 16'h7FFF, 8'h00, 32'hFFFF_FFFF, 14'd0}},
        '{FUNC_FEEDBACK, 2'd1, 11'h201, 16'd8192, 16'd5, 16'd6, 8'd7, 5'd0, 13'd0, 16'd0,
          1'b0, '0},
        '{FUNC_FEEDBACK, 2'd1, 11'h201, 16'd0, 16'd0, 16'd0, 8'd0, 5'd0, 13'd0, 16'd0,
          1'b1, {1'b1, 5'd3, 13'd0, 16'd0, 16'd0, 8'd0, 32'd0, 14'd0}},
        // wrap threshold: just inside, then just past
        '{FUNC_FEEDBACK, 2'd1, 11'h201, 16'd6826, 16'd1, 16'd2, 8'd3, 5'd0, 13'd0, 16'd0,
          1'b0, '0},
        '{FUNC_FEEDBACK, 2'd1, 11'h201, 16'd0, 16'd1, 16'd2, 8'd3, 5'd0, 13'd0, 16'd0,
          1'b0, '0},
        '{FUNC_FEEDBACK, 2'd1, 11'h201, 16'd6827, 16'd1, 16'd2, 8'd3, 5'd0, 13'd0, 16'd0,
          1'b0, '0},
        '{FUNC_FEEDBACK, 2'd1, 11'h201, 16'd0, 16'd1, 16'd2, 8'd3, 5'd0, 13'd0, 16'd0,
          1'b0, '0},
        // absolute slot: differences at and around half a turn
        '{FUNC_FEEDBACK, 2'd2, 11'h201, 16'd100, 16'd9, 16'd8, 8'd7, 5'd0, 13'd0, 16'd0,
          1'b0, '0},
        '{FUNC_TARGET, 2'd0, 11'h000, 16'd0, 16'd0, 16'd0, 8'd0, 5'd7, 13'd4196, 16'hFFFF,
          1'b1, {1'b1, 5'd7, 13'd100, 16'd0, 16'd0, 8'd0, 32'd0, 14'd4096}},
        '{FUNC_FEEDBACK, 2'd2, 11'h201, 16'd99, 16'd9, 16'd8, 8'd7, 5'd0, 13'd0, 16'd0,
          1'b0, '0},
        '{FUNC_TARGET, 2'd3, 11'h555, 16'hAAAA, 16'd1, 16'd1, 8'd1, 5'd7, 13'd0, 16'd0,
          1'b0, '0},
        '{FUNC_FEEDBACK, 2'd2, 11'h201, 16'd4196, 16'd9, 16'd8, 8'd7, 5'd0, 13'd0, 16'd0,
          1'b0, '0},
        '{FUNC_FEEDBACK, 2'd2, 11'h201, 16'd4096, 16'd9, 16'd8, 8'd7, 5'd0, 13'd0, 16'd0,
          1'b0, '0},
        // targets on slots never updated take the type from the table; slot 3 keeps its seen type
        '{FUNC_TARGET, 2'd0, 11'h000, 16'd0, 16'd0, 16'd0, 8'd0, 5'd9, 13'd8191, 16'h7FFF,
          1'b1, {1'b1, 5'd9, 13'd0, 16'd0, 16'd0, 8'd0, 32'd0, 14'h3FFF}},
        '{FUNC_TARGET, 2'd0, 11'h000, 16'd0, 16'd0, 16'd0, 8'd0, 5'd4, 13'd5, 16'h8000,
          1'b0, '0},
        '{FUNC_TARGET, 2'd0, 11'h000, 16'd0, 16'd0, 16'd0, 8'd0, 5'd5, 13'd100, 16'd1,
          1'b1, {1'b1, 5'd5, 13'd0, 16'd0, 16'd0, 8'd0, 32'd0, 14'd0}},
        '{FUNC_TARGET, 2'd0, 11'h000, 16'd0, 16'd0, 16'd0, 8'd0, 5'd3, 13'd1, 16'd2,
          1'b0, '0},
        // no match on the port zero and invalid entries, hits on entries five to seven, then a wrong id
        '{FUNC_FEEDBACK, 2'd0, 11'h7FF, 16'd1, 16'd1, 16'd1, 8'd1, 5'd0, 13'd0, 16'd0,
          1'b1, '0},
        '{FUNC_FEEDBACK, 2'd3, 11'h123, 16'd1, 16'd1, 16'd1, 8'd1, 5'd0, 13'd0, 16'd0,
          1'b1, '0},
        '{FUNC_FEEDBACK, 2'd3, 11'h7FF, 16'd12345, 16'd3, 16'd4, 8'd5, 5'd0, 13'd0, 16'd0,
          1'b0, '0},
        '{FUNC_FEEDBACK, 2'd3, 11'h000, 16'd5, 16'd3, 16'd4, 8'd5, 5'd0, 13'd0, 16'd0,
          1'b0, '0},
        '{FUNC_FEEDBACK, 2'd2, 11'h0AA, 16'd3000, 16'd3, 16'd4, 8'd5, 5'd0, 13'd0, 16'd0,
          1'b0, '0},
        '{FUNC_FEEDBACK, 2'd1, 11'h202, 16'd7, 16'd3, 16'd4, 8'd5, 5'd0, 13'd0, 16'd0,
          1'b1, '0}
    };

    // Shortest signed path from angle to target
    function automatic logic signed [13:0] shortest_offset(input logic [12:0] target,
                                                           input logic [12:0] angle);
        int d;
        d = int'(target) - int'(angle);
        if (d > HALF_TURN) d -= COUNTS_PER_TURN;
        else if (d < -HALF_TURN) d += COUNTS_PER_TURN;
        return 14'(d);
    endfunction

    // Updates the slot state for one item and returns its result
    function automatic t_result track_item(input logic func, input t_frame f);
        t_result     r;
        logic [4:0]  s;
        logic [1:0]  kind;
        logic [12:0] na;
        logic [20:0] e;
        bit          hit;
        int          delta;
        r   = '0;
        hit = 1'b0;
        if (func == FUNC_TARGET) begin
            s = f.target_slot;
            target_mem[s]      = f.goal_angle;
            target_turn_mem[s] = f.target_turns;
            // unseen slot: lowest-priority valid entry naming it decides
            kind = type_mem[s];
            if (!type_seen[s]) begin
                kind = TYPE_INCR_A;
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (table_regs[i][20] && table_regs[i][4:0] == s) kind = table_regs[i][6:5];
                end
            end
            r.matched    = 1'b1;
            r.slot       = s;
            r.angle      = angle_mem[s];
            r.turn_count = turns_mem[s];
            if (kind == TYPE_ABSOLUTE) begin
                diff_mem[s]  = shortest_offset(target_mem[s], angle_mem[s]);
                r.tgt_offset = diff_mem[s];
            end
        end else begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                e = table_regs[i];
                if (!hit && e[20] && e[19:18] != 2'd0 && e[19:18] == f.bus_port &&
                    e[17:7] == f.frame_id) begin
                    hit  = 1'b1;
                    s    = e[4:0];
                    kind = e[6:5];
                    na   = (f.encoder_raw > 16'(COUNTS_PER_TURN - 1)) ?
                           13'(COUNTS_PER_TURN - 1) : f.encoder_raw[12:0];
                    type_mem[s]  = kind;
                    type_seen[s] = 1'b1;
                    if (kind == TYPE_ABSOLUTE) begin
                        diff_mem[s]  = shortest_offset(target_mem[s], na);
                        r.tgt_offset = diff_mem[s];
                        turns_mem[s] = '0;
                    end else begin
                        delta = int'(na) - int'(angle_mem[s]);
                        if (6 * delta < -5 * COUNTS_PER_TURN) turns_mem[s] += 1;
                        else if (6 * delta > 5 * COUNTS_PER_TURN) turns_mem[s] -= 1;
                    end
                    angle_mem[s]  = na;
                    r.matched     = 1'b1;
                    r.slot        = s;
                    r.angle       = na;
                    r.speed       = f.speed_raw;
                    r.current     = f.current_raw;
                    r.temperature = f.temp_raw;
                    r.turn_count  = turns_mem[s];
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Table shadow, prediction at input accept, comparison at output accept
    always @(posedge i_clk) begin
        t_result       want;
        t_typed_result hand;
        if (i_rst_n) begin
            if (i_cfg_we) table_regs[i_cfg_index] = i_cfg_data;
            if (s_axis_tvalid && s_axis_tready) begin
                want = track_item(s_axis_tuser, t_frame'(s_axis_tdata));
                hand = '{on: 1'b0, r: '0};
                if (hand_results.size() != 0) hand = hand_results.pop_front();
                pending_results.push_back(hand.on ? hand.r : want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (m_axis_tuser) matched_seen++;
                if (pending_results.size() == 0) begin
                    $error("result item arrived with nothing outstanding");
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("matched", want.matched, m_axis_tuser);
                    check_field("slot", want.slot, m_axis_tdata[4:0]);
                    check_field("angle", want.angle, m_axis_tdata[17:5]);
                    check_field("speed", want.speed, $signed(m_axis_tdata[33:18]));
                    check_field("current", want.current, $signed(m_axis_tdata[49:34]));
                    check_field("temperature", want.temperature, m_axis_tdata[57:50]);
                    check_field("turn_count", want.turn_count, $signed(m_axis_tdata[89:58]));
                    check_field("tgt_offset", want.tgt_offset, $signed(m_axis_tdata[103:90]));
                end
            end
        end
    end

    // Receiver backpressure: random stall bursts start only while idle_on is set
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(0, 15);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog on cycles with no item moving on either stream
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Offers one item, optionally after a sender gap; returns at its accept edge
    task automatic send_item(input logic func, input t_frame f, input t_typed_result hand);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 16);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        hand_results.push_back(hand);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= f;
        s_axis_tuser  <= func;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // Holds the sender until every outstanding result is back, then settles
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_seen != items_sent) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic load_table(input logic [20:0] regs [REG_COUNT]);
        for (int i = 0; i < REG_COUNT; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= 3'(i);
            i_cfg_data  <= regs[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Stimulus: directed plan, then random phases under several tables
    initial begin
        logic [20:0]   phase_table [REG_COUNT];
        logic [10:0]   id_pool [4];
        logic [4:0]    slot_pool [4];
        logic [12:0]   enc_walk [REG_COUNT];
        logic [20:0]   e;
        logic          func;
        logic [1:0]    port;
        logic [1:0]    kind;
        t_frame        f;
        t_typed_result no_hand;
        int            k;
        int            pick;
        int            count;
        int            tables_used;
        no_hand     = '{on: 1'b0, r: '0};
        tables_used = 1;
        enc_walk    = '{default: '0};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_on = 1'b1;

        load_table(dir_table);
        foreach (plan[n]) begin
            f              = '0;
            f.bus_port     = plan[n].port;
            f.frame_id     = plan[n].id;
            f.encoder_raw  = plan[n].enc;
            f.speed_raw    = plan[n].spd;
            f.current_raw  = plan[n].cur;
            f.temp_raw     = plan[n].temp;
            f.target_slot  = plan[n].tslot;
            f.goal_angle   = plan[n].tangle;
            f.target_turns = plan[n].tturns;
            send_item(plan[n].func, f, '{on: plan[n].on, r: plan[n].gold});
        end
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            // phase 1: every table bit set; phase 3: table cleared
            count = 110;
            if (ph == 1) begin
                phase_table = '{default: '1};
                count = 30;
            end else if (ph == 3) begin
                phase_table = '{default: '0};
                count = 20;
            end else begin
                foreach (id_pool[i]) id_pool[i] = 11'($urandom);
                foreach (slot_pool[i]) slot_pool[i] = 5'($urandom);
                for (int i = 0; i < REG_COUNT; i++) begin
                    port = ($urandom_range(0, 7) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
                    kind = ($urandom_range(0, 1) == 0) ? TYPE_ABSOLUTE : 2'($urandom);
                    phase_table[i] = {($urandom_range(0, 7) != 0), port,
                                      id_pool[$urandom_range(0, 3)], kind,
                                      ($urandom_range(0, 1) == 0) ? slot_pool[$urandom_range(0, 3)]
                                                                  : 5'($urandom)};
                end
            end
            // last phase runs with both sides at full rate
            if (ph == 5) begin
                idle_on = 1'b0;
                count = 100;
            end
            load_table(phase_table);
            tables_used++;

            for (int n = 0; n < count; n++) begin
                k = $urandom_range(0, TABLE_ENTRIES - 1);
                e = phase_table[k];
                f = '0;
                f.bus_port     = 2'($urandom);
                f.frame_id     = 11'($urandom);
                f.encoder_raw  = 16'($urandom);
                f.speed_raw    = 16'($urandom);
                f.current_raw  = 16'($urandom);
                f.temp_raw     = 8'($urandom);
                f.target_slot  = 5'($urandom);
                f.goal_angle   = 13'($urandom);
                f.target_turns = 16'($urandom);
                func = FUNC_FEEDBACK;
                pick = $urandom_range(0, 11);
                if (pick < 2) begin
                    func = FUNC_TARGET;
                    if (pick == 0) f.target_slot = e[4:0];
                end else if (pick < 10) begin
                    // frame aimed at a table entry, encoder mostly walking
                    f.bus_port = e[19:18];
                    f.frame_id = e[17:7];
                    if ($urandom_range(0, 7) != 0) begin
                        enc_walk[k]   = 13'(enc_walk[k] + $urandom_range(0, 3071) - 1535);
                        f.encoder_raw = {3'b000, enc_walk[k]};
                    end
                end
                send_item(func, f, no_hand);
            end
            wait_drained();
        end

        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end
        $display("Ran %0d items over %0d match tables, %0d results checked, %0d matched",
                 items_sent, tables_used, results_seen, matched_seen);
        $display("Covered wraps, saturation, absolute offsets, priority and target fallback");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
